[src/abmg_pkg.sv]
// Shared types and constants for the adjacency bit matrix graph block.
// Used by abmg_rows and adjacency_bit_matrix_graph_top; depends on nothing else.
`default_nettype none

package abmg_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int INDEX_SPAN       = 32;
  localparam int ACT_W            = 3;
  localparam int VTX_W            = 5;
  localparam int CNT_W            = 6;
  localparam int STATUS_W         = 2;
  localparam int TOTAL_W          = 10;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Request action codes; six and seven are ignored.
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEGREE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PRED   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SELF_LOOP = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                edge_present;
    logic [CNT_W-1:0]    degree;
    logic [VTX_W-1:0]    found_vertex;
    logic                found_valid;
    logic                last;
    logic [TOTAL_W-1:0]  edge_total;
  } rsp_t;

  // Write request into the row store.
  typedef struct packed {
    logic                  en;
    logic [VTX_W-1:0]      addr;
    logic [INDEX_SPAN-1:0] data;
  } row_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

[src/abmg_rows.sv]
// Adjacency row store: one row of edge bits per vertex, cleared at reset.
// One registered read port and one write port; uses abmg_pkg.
`default_nettype none

module abmg_rows #(
  parameter int ROWS = abmg_pkg::MAX_VERTICES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [ROWS-1:0]              rd_data,
  input  wire abmg_pkg::row_wr_t       wr
);

  localparam int IW = $clog2(ROWS);

  logic [ROWS-1:0] rows [ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        rows[r] <= '0;
      end
    end else if (wr.en) begin
      rows[wr.addr[IW-1:0]] <= wr.data[ROWS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= rows[rd_addr];
  end

endmodule

`default_nettype wire

[src/adjacency_bit_matrix_graph_top.sv]
// Top level of the adjacency bit matrix graph block: sequencer, scan unit and
// result register. Uses abmg_pkg and abmg_rows.
//
// Usage:
//   cfg    - write channel for vertex_count; always ready. Write it only while
//            the block is idle. Counts above the vertex limit are saturated.
//   req    - one request per handshake: add, remove, check, degree, list
//            successors or list predecessors. req_ready is high only while the
//            sequencer is idle.
//   rsp    - results in order through a single output register. A listing
//            gives one result per vertex found, ascending, the final one with
//            last set, or one empty result if none is found; every other request gives exactly one result.
// Sequencing: add, remove, check and ignored codes load their result from the
//   execute state and return to idle, after which the next request can be
//   accepted. Degree and listings step one vertex per cycle through the shared
//   scan counter, holding while a found vertex waits for the output register.
// The next request is accepted while a result still waits in the output
//   register; the sequencer stalls when the receiver has not taken the previous
//   result and it must load a new one or leave the execute state.
// Reset clears the adjacency rows, the edge count and vertex_count at once.
`default_nettype none

module adjacency_bit_matrix_graph_top #(
  parameter int MAX_VERTICES = abmg_pkg::MAX_VERTICES_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [abmg_pkg::CNT_W-1:0]   cfg_data,
  input  wire                               req_valid,
  output logic                              req_ready,
  input  wire abmg_pkg::req_t               req,
  output logic                              rsp_valid,
  input  wire                               rsp_ready,
  output abmg_pkg::rsp_t                    rsp
);

  localparam int VL = (MAX_VERTICES < abmg_pkg::INDEX_SPAN) ?
                      MAX_VERTICES : abmg_pkg::INDEX_SPAN;
  localparam int IW = $clog2(VL);
  localparam logic [abmg_pkg::CNT_W-1:0] VL_N = abmg_pkg::CNT_W'(VL);

  abmg_pkg::state_t  state, state_next;
  abmg_pkg::req_t    cur;
  abmg_pkg::rsp_t    out_next;
  abmg_pkg::row_wr_t wr;

  logic [abmg_pkg::CNT_W-1:0]   vertex_count;
  logic [abmg_pkg::CNT_W-1:0]   n_act;
  logic [abmg_pkg::TOTAL_W-1:0] edge_cnt, edge_cnt_next;
  logic [VL-1:0]                rd_data, mask;
  logic [IW-1:0]                rd_addr;
  logic [abmg_pkg::CNT_W-1:0]   idx, idx_inc, deg;
  logic [abmg_pkg::VTX_W-1:0]   pend_vtx;
  logic                         pend_valid;

  logic accept, out_free, out_load, scan_adv, hit, last_step;
  logic a_ok, both_ok, row_bit, is_scan_op;

  abmg_rows #(.ROWS(VL)) u_rows (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = (state == abmg_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign n_act   = (vertex_count < VL_N) ? vertex_count : VL_N;
  assign a_ok    = {1'b0, cur.vertex_a} < n_act;
  assign both_ok = a_ok && ({1'b0, cur.vertex_b} < n_act);
  assign mask    = VL'(1) << cur.vertex_b[IW-1:0];
  assign row_bit = rd_data[cur.vertex_b[IW-1:0]];

  assign is_scan_op = (cur.action == abmg_pkg::ACT_DEGREE) ||
                      (cur.action == abmg_pkg::ACT_SUCC) ||
                      (cur.action == abmg_pkg::ACT_PRED);

  // The row of vertex_a is read at accept and stays addressed for every
  // request but a predecessor listing. That one reads the row of each vertex
  // under test, addressed in the cycle before the test.
  always_comb begin
    priority if (state == abmg_pkg::S_IDLE) begin
      rd_addr = req.vertex_a[IW-1:0];
    end else if (cur.action != abmg_pkg::ACT_PRED) begin
      rd_addr = cur.vertex_a[IW-1:0];
    end else if (scan_adv) begin
      rd_addr = idx_inc[IW-1:0];
    end else begin
      rd_addr = idx[IW-1:0];
    end
  end

  assign idx_inc   = idx + abmg_pkg::CNT_W'(1);
  assign last_step = (idx_inc == n_act);
  assign hit       = (cur.action == abmg_pkg::ACT_PRED) ? rd_data[cur.vertex_a[IW-1:0]]
                                                        : rd_data[idx[IW-1:0]];

  always_comb begin
    state_next = state;
    unique case (state)
      abmg_pkg::S_IDLE: begin
        if (accept) state_next = abmg_pkg::S_EXEC;
      end
      abmg_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = (is_scan_op && a_ok) ? abmg_pkg::S_SCAN : abmg_pkg::S_IDLE;
        end
      end
      abmg_pkg::S_SCAN: begin
        if (scan_adv && last_step) state_next = abmg_pkg::S_FINISH;
      end
      abmg_pkg::S_FINISH: begin
        if (out_free) state_next = abmg_pkg::S_IDLE;
      end
      default: state_next = abmg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_load      = 1'b0;
    out_next      = '0;
    out_next.last = 1'b1;
    wr            = '0;
    edge_cnt_next = edge_cnt;
    scan_adv      = 1'b0;
    unique case (state)
      abmg_pkg::S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (cur.action)
            abmg_pkg::ACT_ADD: begin
              if (!both_ok) begin
                out_next.status = abmg_pkg::ST_RANGE;
              end else if (cur.vertex_a == cur.vertex_b) begin
                out_next.status = abmg_pkg::ST_SELF_LOOP;
              end else if (!row_bit) begin
                wr.en   = 1'b1;
                wr.addr = cur.vertex_a;
                wr.data = abmg_pkg::INDEX_SPAN'(rd_data | mask);
                if (edge_cnt != abmg_pkg::TOTAL_MAX) begin
                  edge_cnt_next = edge_cnt + abmg_pkg::TOTAL_W'(1);
                end
              end
            end
            abmg_pkg::ACT_REMOVE: begin
              if (!both_ok) begin
                out_next.status = abmg_pkg::ST_RANGE;
              end else if (row_bit) begin
                wr.en   = 1'b1;
                wr.addr = cur.vertex_a;
                wr.data = abmg_pkg::INDEX_SPAN'(rd_data & ~mask);
                if (edge_cnt != '0) begin
                  edge_cnt_next = edge_cnt - abmg_pkg::TOTAL_W'(1);
                end
              end
            end
            abmg_pkg::ACT_CHECK: begin
              if (!both_ok) out_next.status = abmg_pkg::ST_RANGE;
              else          out_next.edge_present = row_bit;
            end
            abmg_pkg::ACT_DEGREE, abmg_pkg::ACT_SUCC, abmg_pkg::ACT_PRED: begin
              // In range: no result yet, the scan follows.
              if (!a_ok) out_next.status = abmg_pkg::ST_RANGE;
              else       out_load = 1'b0;
            end
            default: ;
          endcase
        end
      end
      abmg_pkg::S_SCAN: begin
        // A found vertex is held back until the next one turns up, so that
        // the final result of a listing can carry last.
        if (cur.action != abmg_pkg::ACT_DEGREE && hit && pend_valid) begin
          if (out_free) begin
            out_load              = 1'b1;
            out_next.found_vertex = pend_vtx;
            out_next.found_valid  = 1'b1;
            out_next.last         = 1'b0;
            scan_adv              = 1'b1;
          end
        end else begin
          scan_adv = 1'b1;
        end
      end
      abmg_pkg::S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cur.action == abmg_pkg::ACT_DEGREE) begin
            out_next.degree = deg;
          end else if (pend_valid) begin
            out_next.found_vertex = pend_vtx;
            out_next.found_valid  = 1'b1;
          end
        end
      end
      default: ;
    endcase
    out_next.edge_total = edge_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= abmg_pkg::S_IDLE;
      rsp_valid    <= 1'b0;
      vertex_count <= '0;
      edge_cnt     <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      edge_cnt <= edge_cnt_next;
      if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
      if (out_load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (accept) begin
        pend_valid <= 1'b0;
      end else if (scan_adv && hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
      idx <= '0;
      deg <= '0;
    end else if (scan_adv) begin
      idx <= idx_inc;
      deg <= deg + abmg_pkg::CNT_W'(hit);
      if (hit) pend_vtx <= idx[abmg_pkg::VTX_W-1:0];
    end
    if (out_load) rsp <= out_next;
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for adjacency_bit_matrix_graph_top: random and directed
// requests are checked against a predictor that keeps its own copy of the bit matrix.
// Depends on abmg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int VERTEX_LIMIT =
    (abmg_pkg::MAX_VERTICES_DEF < abmg_pkg::INDEX_SPAN) ?
    abmg_pkg::MAX_VERTICES_DEF : abmg_pkg::INDEX_SPAN;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  // Action codes that the block ignores.
  localparam logic [abmg_pkg::ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [abmg_pkg::ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_CFG,
    OP_DRAIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t                   kind;
    abmg_pkg::req_t             req;
    logic [abmg_pkg::CNT_W-1:0] cfg;
    logic [7:0]                 gap;
  } graph_op_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [abmg_pkg::CNT_W-1:0] cfg_data = '0;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  abmg_pkg::req_t             req = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  abmg_pkg::rsp_t             rsp;

  adjacency_bit_matrix_graph_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Predictor copy of the graph.
  logic [abmg_pkg::INDEX_SPAN-1:0] graph_rows [abmg_pkg::INDEX_SPAN];
  logic [abmg_pkg::TOTAL_W-1:0]    graph_edges = '0;
  logic [abmg_pkg::CNT_W-1:0]      graph_vcount = '0;

  graph_op_t      pending_ops [$];
  abmg_pkg::rsp_t expected_rsp_q [$];

  int errors = 0;
  int n_reqs = 0;
  int n_cfgs = 0;
  int n_results = 0;
  int n_found = 0;
  int quiet_cycles = 0;
  int idle_count = 0;

  // Driver variables.
  graph_op_t cur_op;
  logic      have_op = 1'b0;
  int        gap_left = 0;
  logic      next_req_valid;
  logic      next_cfg_valid;

  // Monitor variables.
  abmg_pkg::rsp_t want;
  int             stall_left = 0;
  int             mode_left = 0;
  int             stall_len;
  logic           calm_rx = 1'b0;

  initial begin
    for (int i = 0; i < abmg_pkg::INDEX_SPAN; i++) graph_rows[i] = '0;
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rand_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void expect_rsp(input abmg_pkg::rsp_t r);
    expected_rsp_q.insert(expected_rsp_q.size(), r);
  endfunction

  function automatic void queue_op(input graph_op_t op);
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  // Works out every result that one request causes and queues them in order.
  function automatic void predict_graph(input abmg_pkg::req_t r);
    int                              n;
    int                              i;
    int                              hits;
    int                              k;
    logic                            a_ok;
    logic                            both_ok;
    logic                            listed;
    logic [abmg_pkg::INDEX_SPAN-1:0] found;
    abmg_pkg::rsp_t                  o;
    abmg_pkg::rsp_t                  hit_rsp;
    n = (int'(graph_vcount) > VERTEX_LIMIT) ? VERTEX_LIMIT : int'(graph_vcount);
    a_ok = int'(r.vertex_a) < n;
    both_ok = a_ok && (int'(r.vertex_b) < n);
    listed = 1'b0;
    o = '0;
    o.last = 1'b1;
    case (r.action)
      abmg_pkg::ACT_ADD: begin
        if (!both_ok) o.status = abmg_pkg::ST_RANGE;
        else if (r.vertex_a == r.vertex_b) o.status = abmg_pkg::ST_SELF_LOOP;
        else if (!graph_rows[r.vertex_a][r.vertex_b]) begin
          graph_rows[r.vertex_a][r.vertex_b] = 1'b1;
          if (graph_edges != abmg_pkg::TOTAL_MAX)
            graph_edges = graph_edges + abmg_pkg::TOTAL_W'(1);
        end
      end
      abmg_pkg::ACT_REMOVE: begin
        if (!both_ok) o.status = abmg_pkg::ST_RANGE;
        else if (graph_rows[r.vertex_a][r.vertex_b]) begin
          graph_rows[r.vertex_a][r.vertex_b] = 1'b0;
          if (graph_edges != '0) graph_edges = graph_edges - abmg_pkg::TOTAL_W'(1);
        end
      end
      abmg_pkg::ACT_CHECK: begin
        if (!both_ok) o.status = abmg_pkg::ST_RANGE;
        else o.edge_present = graph_rows[r.vertex_a][r.vertex_b];
      end
      abmg_pkg::ACT_DEGREE: begin
        if (!a_ok) o.status = abmg_pkg::ST_RANGE;
        else begin
          for (i = 0; i < n; i++)
            o.degree = o.degree + abmg_pkg::CNT_W'(graph_rows[r.vertex_a][i]);
        end
      end
      abmg_pkg::ACT_SUCC, abmg_pkg::ACT_PRED: begin
        if (!a_ok) o.status = abmg_pkg::ST_RANGE;
        else begin
          found = '0;
          for (i = 0; i < n; i++) begin
            if (r.action == abmg_pkg::ACT_SUCC) found[i] = graph_rows[r.vertex_a][i];
            else found[i] = graph_rows[i][r.vertex_a];
          end
          hits = $countones(found);
          k = 0;
          for (i = 0; i < n; i++) begin
            if (found[i]) begin
              k++;
              hit_rsp = '0;
              hit_rsp.found_vertex = abmg_pkg::VTX_W'(i);
              hit_rsp.found_valid = 1'b1;
              hit_rsp.last = (k == hits);
              hit_rsp.edge_total = graph_edges;
              expect_rsp(hit_rsp);
            end
          end
          listed = (hits != 0);
        end
      end
      default: begin
      end
    endcase
    o.edge_total = graph_edges;
    if (!listed) expect_rsp(o);
  endfunction

  function automatic void check_field(input string fname, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
      errors++;
    end
  endfunction

  // Driver: presents requests and register writes from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      cfg_valid <= 1'b0;
      have_op = 1'b0;
    end else begin
      next_req_valid = req_valid;
      next_cfg_valid = cfg_valid;
      if (req_valid && req_ready) begin
        predict_graph(req);
        next_req_valid = 1'b0;
        n_reqs++;
      end
      if (cfg_valid && cfg_ready) begin
        graph_vcount = cfg_data;
        next_cfg_valid = 1'b0;
        n_cfgs++;
      end
      if (!next_req_valid && !next_cfg_valid) begin
        if (!have_op && pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          have_op = 1'b1;
          gap_left = cur_op.gap;
        end
        if (have_op) begin
          if (gap_left != 0) gap_left--;
          else begin
            case (cur_op.kind)
              OP_REQ: begin
                next_req_valid = 1'b1;
                req <= cur_op.req;
                have_op = 1'b0;
              end
              OP_CFG: begin
                // The register is only written once the block has gone quiet.
                if (expected_rsp_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                  next_cfg_valid = 1'b1;
                  cfg_data <= cur_op.cfg;
                  have_op = 1'b0;
                end
              end
              default: begin
                if (expected_rsp_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                  have_op = 1'b0;
              end
            endcase
          end
        end
      end
      req_valid <= next_req_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // Monitor: checks each result against the oldest expectation and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_results++;
        if (rsp.found_valid) n_found++;
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding: %p", rsp);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("edge_present", want.edge_present, rsp.edge_present);
          check_field("degree", want.degree, rsp.degree);
          check_field("found_vertex", want.found_vertex, rsp.found_vertex);
          check_field("found_valid", want.found_valid, rsp.found_valid);
          check_field("last", want.last, rsp.last);
          check_field("edge_total", want.edge_total, rsp.edge_total);
        end
      end
      if (expected_rsp_q.size() == 0) begin
        if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
      end else quiet_cycles = 0;

      if (mode_left == 0) begin
        calm_rx = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(20, 120);
      end else mode_left--;

      if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        stall_len = ($urandom_range(0, 99) < 30) ? rand_gap(calm_rx) : 0;
        if (stall_len != 0) begin
          stall_left = stall_len - 1;
          rsp_ready <= 1'b0;
        end else rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (cfg_valid && cfg_ready) ||
        (rsp_valid && rsp_ready))
      idle_count <= 0;
    else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [abmg_pkg::ACT_W-1:0] action, input int a,
                          input int b, input logic calm);
    graph_op_t op;
    op = '0;
    op.kind = OP_REQ;
    op.req.action = action;
    op.req.vertex_a = abmg_pkg::VTX_W'(a);
    op.req.vertex_b = abmg_pkg::VTX_W'(b);
    op.gap = 8'(rand_gap(calm));
    queue_op(op);
  endtask

  task automatic push_cfg(input int value);
    graph_op_t op;
    op = '0;
    op.kind = OP_CFG;
    op.cfg = abmg_pkg::CNT_W'(value);
    op.gap = 8'(rand_gap(1'b0));
    queue_op(op);
  endtask

  task automatic push_drain();
    graph_op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    queue_op(op);
  endtask

  function automatic logic [abmg_pkg::ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return abmg_pkg::ACT_ADD;
    if (r < 50) return abmg_pkg::ACT_REMOVE;
    if (r < 63) return abmg_pkg::ACT_CHECK;
    if (r < 73) return abmg_pkg::ACT_DEGREE;
    if (r < 83) return abmg_pkg::ACT_SUCC;
    if (r < 93) return abmg_pkg::ACT_PRED;
    return ($urandom_range(0, 1) != 0) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
  endfunction

  // Mostly indices in range, so that edges build up; the rest anywhere.
  function automatic int pick_vertex(input int n);
    if (n > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, abmg_pkg::INDEX_SPAN - 1);
  endfunction

  initial begin
    int phase_cfg [6];
    int phase_len [6];
    int eff;
    logic calm;

    // With no vertices in use the add and degree requests are out of range.
    push_req(abmg_pkg::ACT_ADD, 0, 1, 1'b0);
    push_req(abmg_pkg::ACT_DEGREE, 0, 0, 1'b0);
    push_req(ACT_UNUSED_LO, 0, 0, 1'b0);
    push_cfg(5);
    push_req(abmg_pkg::ACT_ADD, 0, 1, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 0, 1, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 2, 2, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 4, 5, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 31, 31, 1'b0);
    push_req(abmg_pkg::ACT_CHECK, 0, 1, 1'b0);
    push_req(abmg_pkg::ACT_CHECK, 1, 0, 1'b0);
    push_req(abmg_pkg::ACT_REMOVE, 1, 0, 1'b0);
    push_req(abmg_pkg::ACT_REMOVE, 0, 1, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 0, 1, 1'b1);
    push_req(abmg_pkg::ACT_ADD, 0, 4, 1'b1);
    push_req(abmg_pkg::ACT_ADD, 3, 4, 1'b1);
    push_req(abmg_pkg::ACT_DEGREE, 0, 0, 1'b0);
    push_req(abmg_pkg::ACT_SUCC, 0, 0, 1'b0);
    push_req(abmg_pkg::ACT_PRED, 4, 0, 1'b0);
    push_req(abmg_pkg::ACT_SUCC, 2, 0, 1'b0);
    push_req(abmg_pkg::ACT_PRED, 9, 0, 1'b0);
    push_req(ACT_UNUSED_HI, 31, 31, 1'b0);
    // Lowering the count hides stored edges from scans but keeps them counted.
    push_cfg(3);
    push_req(abmg_pkg::ACT_DEGREE, 0, 0, 1'b0);
    push_req(abmg_pkg::ACT_SUCC, 0, 0, 1'b0);
    push_req(abmg_pkg::ACT_CHECK, 0, 4, 1'b0);
    // A count above the limit saturates.
    push_cfg(63);
    push_req(abmg_pkg::ACT_ADD, 31, 0, 1'b0);
    push_req(abmg_pkg::ACT_ADD, 0, 31, 1'b0);
    push_req(abmg_pkg::ACT_PRED, 31, 0, 1'b0);
    push_req(abmg_pkg::ACT_SUCC, 0, 0, 1'b0);

    phase_cfg[0] = 2;
    phase_cfg[1] = 32;
    phase_cfg[2] = $urandom_range(3, 31);
    phase_cfg[3] = 0;
    phase_cfg[4] = $urandom_range(1, 63);
    phase_cfg[5] = 63;
    phase_len[0] = 15;
    phase_len[1] = 20;
    phase_len[2] = 20;
    phase_len[3] = 5;
    phase_len[4] = 17;
    phase_len[5] = 15;
    for (int p = 0; p < 6; p++) begin
      push_cfg(phase_cfg[p]);
      eff = (phase_cfg[p] > VERTEX_LIMIT) ? VERTEX_LIMIT : phase_cfg[p];
      calm = (p == 1 || p == 4);
      for (int j = 0; j < phase_len[p]; j++) begin
        // Hold the sender back once until every result has come.
        if (p == 2 && j == phase_len[p] / 2) push_drain();
        push_req(pick_action(), pick_vertex(eff), pick_vertex(eff), calm);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || have_op || req_valid || cfg_valid) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d register settings, %0d results checked (%0d listed).",
             n_reqs, n_cfgs, n_results, n_found);
    $display("Final predicted graph holds %0d edges.", graph_edges);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

[filelist.f]
src/abmg_pkg.sv
src/abmg_rows.sv
src/adjacency_bit_matrix_graph_top.sv
tb/tb_top.sv
